// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the rtl top level of the process selector
// depends on nothing; defining SYNTH turns every macro into an empty body
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_CHK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CHK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

// ===== rtl/core/mlfq_pkg.sv =====
// shared types, codes and defaults of the multilevel feedback queue selector
// depends on nothing; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package mlfq_pkg;

  // default sizes
  localparam int SLOTS_DEF      = 32;
  localparam int MAX_LEVELS_DEF = 8;

  // fixed field widths
  localparam int STATUS_W  = 3;
  localparam int SLOT_F_W  = 5;
  localparam int LEVEL_F_W = 3;
  localparam int PRIO_W    = 8;
  localparam int TICK_W    = 32;
  localparam int SLICE_W   = 32;
  localparam int COUNT_W   = 16;
  localparam int QUANTUM_W = 16;
  localparam int LCOUNT_W  = 4;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [SLOT_F_W-1:0]  slot_t;
  typedef logic [LEVEL_F_W-1:0] level_t;
  typedef logic [PRIO_W-1:0]    prio_t;
  typedef logic [TICK_W-1:0]    tick_t;
  typedef logic signed [SLICE_W-1:0] slice_t;
  typedef logic [COUNT_W-1:0]   count_t;

  // request function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_SCHED = 1'b1;

  // process status codes
  localparam status_t STAT_EMPTY   = 3'd0;
  localparam status_t STAT_NEW     = 3'd1;
  localparam status_t STAT_READY   = 3'd2;
  localparam status_t STAT_RUNNING = 3'd3;

  // configuration register indexes
  localparam logic [1:0] REG_BOOST_ON       = 2'd0;
  localparam logic [1:0] REG_BOOST_INTERVAL = 2'd1;
  localparam logic [1:0] REG_LEVEL_COUNT    = 2'd2;
  localparam logic [1:0] REG_SLICE_UNIT     = 2'd3;

  // configuration reset values
  localparam logic                 BOOST_ON_RST       = 1'b0;
  localparam logic [TICK_W-1:0]    BOOST_INTERVAL_RST = 32'd100;
  localparam logic [LCOUNT_W-1:0]  LEVEL_COUNT_RST    = 4'd3;
  localparam logic [QUANTUM_W-1:0] SLICE_UNIT_RST     = 16'd10;

endpackage

// ===== rtl/core/mlfq_req_if.sv =====
// request channel of the selector: slot write or schedule beat
// depends on mlfq_pkg
`timescale 1ns / 1ps

interface mlfq_req_if import mlfq_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    func;
  slot_t   slot;
  status_t proc_status;
  level_t  level_in;
  prio_t   priority_in;
  tick_t   created_in;
  slice_t  slice_left_in;
  count_t  yields_in;
  count_t  preempts_in;
  tick_t   now_tick;

  modport source (
    output valid, func, slot, proc_status, level_in, priority_in, created_in,
           slice_left_in, yields_in, preempts_in, now_tick,
    input  ready
  );

  modport sink (
    input  valid, func, slot, proc_status, level_in, priority_in, created_in,
           slice_left_in, yields_in, preempts_in, now_tick,
    output ready
  );
endinterface

// ===== rtl/core/mlfq_rsp_if.sv =====
// response channel of the selector: one beat per schedule decision
// depends on mlfq_pkg
`timescale 1ns / 1ps

interface mlfq_rsp_if import mlfq_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   found;
  slot_t  chosen_slot;
  level_t chosen_level;
  slice_t chosen_slice;
  logic   boosted;

  modport source (
    output valid, found, chosen_slot, chosen_level, chosen_slice, boosted,
    input  ready
  );

  modport sink (
    input  valid, found, chosen_slot, chosen_level, chosen_slice, boosted,
    output ready
  );
endinterface

// ===== rtl/core/mlfq_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/mlfq_process_selector.sv =====
// multilevel feedback queue process selector, top level
// write beat: taken while idle, no response beat
// schedule beat: the table is walked with one table read per slot, then the response register is
//   loaded in the done state, which a stalled sink holds; the next beat is taken back in idle
// reset: config back to defaults, all slots empty through valid flops, no clearing pass
// depends on mlfq_pkg, mlfq_req_if, mlfq_rsp_if, mlfq_ram, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mlfq_process_selector import mlfq_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  mlfq_req_if.sink           req,
  mlfq_rsp_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // internal level width: the 3-bit field, wider when more levels are allowed
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LVL_W   = (MAX_LEVELS > 8) ? $clog2(MAX_LEVELS) : LEVEL_F_W;
  localparam int PROD_W  = QUANTUM_W + LVL_W + 1;
  localparam int ENTRY_W = STATUS_W + LVL_W + PRIO_W + TICK_W + SLICE_W + 2 * COUNT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // ---------------------------------------------------------------------------
  // configuration registers on the apb port
  // ---------------------------------------------------------------------------
  logic                 boost_on;
  logic [TICK_W-1:0]    boost_interval;
  logic [LCOUNT_W-1:0]  level_count;
  logic [QUANTUM_W-1:0] slice_unit;
  logic                 cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      boost_on       <= BOOST_ON_RST;
      boost_interval <= BOOST_INTERVAL_RST;
      level_count    <= LEVEL_COUNT_RST;
      slice_unit     <= SLICE_UNIT_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_BOOST_ON:       boost_on       <= pwdata[0];
        REG_BOOST_INTERVAL: boost_interval <= pwdata[TICK_W-1:0];
        REG_LEVEL_COUNT:    level_count    <= pwdata[LCOUNT_W-1:0];
        REG_SLICE_UNIT:     slice_unit     <= pwdata[QUANTUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BOOST_ON:       prdata = {{(PDATA_W-1){1'b0}}, boost_on};
      REG_BOOST_INTERVAL: prdata = boost_interval;
      REG_LEVEL_COUNT:    prdata = {{(PDATA_W-LCOUNT_W){1'b0}}, level_count};
      REG_SLICE_UNIT:     prdata = {{(PDATA_W-QUANTUM_W){1'b0}}, slice_unit};
      default:            prdata = '0;
    endcase
  end

  // bottom level: level_count clamped to 1..MAX_LEVELS, minus one
  logic [4:0] lc_eff;
  logic [4:0] bottom;

  always_comb begin
    if (level_count == '0) begin
      lc_eff = 5'd1;
    end else if ({1'b0, level_count} > 5'(MAX_LEVELS)) begin
      lc_eff = 5'(MAX_LEVELS);
    end else begin
      lc_eff = {1'b0, level_count};
    end
    bottom = lc_eff - 5'd1;
  end

  // ---------------------------------------------------------------------------
  // sequencer state
  // ---------------------------------------------------------------------------
  logic [1:0]        state;
  logic              issuing;    // a table read goes out this cycle
  logic [SLOT_W-1:0] issue_idx;  // slot being read
  logic              proc_vld;   // ram data for proc_idx is on the read port
  logic [SLOT_W-1:0] proc_idx;
  logic              do_boost;   // boost decided at accept, applied per slot
  logic [TICK_W-1:0] last_boost_tick;
  logic [SLOTS-1:0]  valid;      // slot written since reset

  logic req_acc;
  logic sched_acc;
  logic wr_acc;
  logic boost_now;

  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign sched_acc = req_acc && (req.func == FUNC_SCHED);
  // writes beyond the table are dropped
  assign wr_acc    = req_acc && (req.func == FUNC_WRITE) && (int'(req.slot) < SLOTS);
  // tick distance wraps modulo 2^32
  assign boost_now = boost_on && ((req.now_tick - last_boost_tick) >= boost_interval);

  // ---------------------------------------------------------------------------
  // slot table: one ram word per slot, walked one slot per cycle
  // ---------------------------------------------------------------------------
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  mlfq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_idx),
    .rdata (ram_rdata)
  );

  // fields of the slot on the read port
  status_t              rd_st_raw;
  status_t              rd_st;
  logic [LVL_W-1:0]     rd_lvl;
  prio_t                rd_prio;
  tick_t                rd_created;
  logic [SLICE_W-1:0]   rd_slice;
  count_t               rd_yields;
  count_t               rd_preempts;

  assign {rd_st_raw, rd_lvl, rd_prio, rd_created, rd_slice, rd_yields, rd_preempts} =
    ram_rdata;
  // a slot never written reads as empty
  assign rd_st = valid[proc_idx] ? rd_st_raw : STAT_EMPTY;

  // ---------------------------------------------------------------------------
  // shared update unit: demote, promote, boost, then compare against the best
  // ---------------------------------------------------------------------------
  logic               demote;
  logic               promote;
  logic [LVL_W-1:0]   lvl1;
  logic [LVL_W-1:0]   lvl2;
  logic [LVL_W:0]     lvl2_inc;
  logic [PROD_W-1:0]  prod;
  logic [SLICE_W-1:0] slice2;
  logic [LVL_W-1:0]   lvl3;
  logic [SLICE_W-1:0] slice3;
  logic               cand;
  logic               better;

  // best entry so far
  logic               best_found;
  logic [SLOT_W-1:0]  best_idx;
  logic [LVL_W-1:0]   best_lvl;
  prio_t              best_prio;
  tick_t              best_created;
  logic [SLICE_W-1:0] best_slice;

  always_comb begin
    // running with its slice used up (zero or negative) drops one level, unless at the bottom
    demote = (rd_st == STAT_RUNNING) && ((rd_slice == '0) || rd_slice[SLICE_W-1]) &&
             (5'(rd_lvl) < bottom);
    lvl1   = demote ? rd_lvl + LVL_W'(1) : rd_lvl;
    // more yields than preemptions climbs one level, unless already at level zero
    promote = (rd_yields > rd_preempts) && (lvl1 != '0);
    lvl2    = promote ? lvl1 - LVL_W'(1) : lvl1;
    // any level change reloads the slice for the final level
    lvl2_inc = (LVL_W+1)'(lvl2) + (LVL_W+1)'(1);
    prod     = PROD_W'(slice_unit) * PROD_W'(lvl2_inc);
    slice2   = (demote || promote) ? SLICE_W'(prod) : rd_slice;
    // boost lifts everything above level zero
    if (do_boost && (lvl2 != '0)) begin
      lvl3   = '0;
      slice3 = SLICE_W'(slice_unit);
    end else begin
      lvl3   = lvl2;
      slice3 = slice2;
    end
    // new, ready and running entries compete; earlier slot wins full ties
    cand   = rd_st inside {STAT_NEW, STAT_READY, STAT_RUNNING};
    better = !best_found || (lvl3 < best_lvl) ||
             ((lvl3 == best_lvl) && ((rd_prio < best_prio) ||
              ((rd_prio == best_prio) && (rd_created < best_created))));
  end

  // write port: slot write beat in idle, write back during the walk
  always_comb begin
    if (state == S_WALK) begin
      ram_we    = proc_vld && (rd_st != STAT_EMPTY);
      ram_waddr = proc_idx;
      ram_wdata = {rd_st, lvl3, rd_prio, rd_created, slice3, rd_yields, rd_preempts};
    end else begin
      ram_we    = wr_acc;
      ram_waddr = SLOT_W'(req.slot);
      ram_wdata = {req.proc_status, LVL_W'(req.level_in), req.priority_in, req.created_in,
                   req.slice_left_in, req.yields_in, req.preempts_in};
    end
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  logic out_valid;
  logic out_load;

  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      issuing         <= 1'b0;
      issue_idx       <= '0;
      proc_vld        <= 1'b0;
      proc_idx        <= '0;
      do_boost        <= 1'b0;
      last_boost_tick <= '0;
      valid           <= '0;
      best_found      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (wr_acc) begin
        valid[SLOT_W'(req.slot)] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sched_acc) begin
            state      <= S_WALK;
            issuing    <= 1'b1;
            issue_idx  <= '0;
            proc_vld   <= 1'b0;
            best_found <= 1'b0;
            do_boost   <= boost_now;
            if (boost_now) begin
              last_boost_tick <= req.now_tick;
            end
          end
        end
        S_WALK: begin
          // read side runs one slot ahead of the update side
          proc_vld <= issuing;
          proc_idx <= issue_idx;
          if (issuing) begin
            if (issue_idx == LAST_SLOT) begin
              issuing <= 1'b0;
            end else begin
              issue_idx <= issue_idx + SLOT_W'(1);
            end
          end
          if (proc_vld) begin
            if (cand && better) begin
              best_found <= 1'b1;
            end
            if (proc_idx == LAST_SLOT) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // best entry payload, cleared at the start of each decision
  always_ff @(posedge clk) begin
    if (sched_acc) begin
      best_idx     <= '0;
      best_lvl     <= '0;
      best_prio    <= '0;
      best_created <= '0;
      best_slice   <= '0;
    end else if ((state == S_WALK) && proc_vld && cand && better) begin
      best_idx     <= proc_idx;
      best_lvl     <= lvl3;
      best_prio    <= rd_prio;
      best_created <= rd_created;
      best_slice   <= slice3;
    end
  end

  // ---------------------------------------------------------------------------
  // response register, holds while the sink stalls
  // ---------------------------------------------------------------------------
  logic               out_found;
  slot_t              out_slot;
  level_t             out_level;
  logic [SLICE_W-1:0] out_slice;
  logic               out_boosted;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found   <= best_found;
      out_slot    <= SLOT_F_W'(best_idx);
      out_level   <= best_lvl[LEVEL_F_W-1:0];
      out_slice   <= best_slice;
      out_boosted <= do_boost;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.found        = out_found;
  assign rsp.chosen_slot  = out_slot;
  assign rsp.chosen_level = out_level;
  assign rsp.chosen_slice = out_slice;
  assign rsp.boosted      = out_boosted;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `ASSERT_CHK(a_sched_starts_walk, clk, rst,
    sched_acc |=> (state == S_WALK) && issuing && !proc_vld,
    "schedule beat did not start the table walk")
  `ASSERT_NEVER(a_wb_read_clash, clk, rst,
    (state == S_WALK) && ram_we && issuing && (ram_waddr == issue_idx),
    "write back hit the slot being read")
  `ASSERT_CHK(a_rsp_from_done, clk, rst,
    $rose(rsp.valid) |-> ($past(state) == S_DONE),
    "response beat raised outside the done state")
  `ASSERT_CHK(a_none_found_zero, clk, rst,
    (rsp.valid && !rsp.found) |->
      ((rsp.chosen_slot == '0) && (rsp.chosen_level == '0) && (rsp.chosen_slice == '0)),
    "empty decision carries nonzero slot fields")

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the multilevel feedback queue process selector
// depends on mlfq_pkg, mlfq_req_if, mlfq_rsp_if and the rtl top mlfq_process_selector
// directed table cases, register corners, then randomized traffic with handshake stalls
`timescale 1ns / 1ps

module testbench;
  import mlfq_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  // a decision walks every slot, plus some margin before a register write
  localparam int SETTLE_CYCLES = NSLOT + 8;
  localparam int DRAIN_LIMIT = 5000;
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 250000;
  localparam int MAX_REPORTS = 10;
  localparam int SCHED_PCT = 40;

  // status codes beyond the schedulable ones
  localparam status_t STAT_BLOCKED = 3'd4;
  localparam status_t STAT_OTHER_LO = 3'd5;
  localparam status_t STAT_OTHER_HI = 3'd7;

  // one request beat as the sender sees it
  typedef struct {
    logic    func;
    slot_t   slot;
    status_t status;
    level_t  level;
    prio_t   prio;
    tick_t   created;
    slice_t  slice;
    count_t  yields;
    count_t  preempts;
    tick_t   now;
  } req_beat_t;

  // one expected decision beat
  typedef struct {
    logic   found;
    slot_t  slot;
    level_t level;
    slice_t slice;
    logic   boosted;
  } pick_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  mlfq_req_if req_ch ();
  mlfq_rsp_if rsp_ch ();

  mlfq_process_selector u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the process table and of the registers
  status_t tab_status   [NSLOT];
  level_t  tab_level    [NSLOT];
  prio_t   tab_prio     [NSLOT];
  tick_t   tab_created  [NSLOT];
  slice_t  tab_slice    [NSLOT];
  count_t  tab_yields   [NSLOT];
  count_t  tab_preempts [NSLOT];
  tick_t   last_boost;

  logic                 cfg_boost_on;
  logic [TICK_W-1:0]    cfg_interval;
  logic [LCOUNT_W-1:0]  cfg_levels;
  logic [QUANTUM_W-1:0] cfg_quantum;

  // decisions accepted by the block whose response beat is still due
  pick_t expected_picks [$];

  // run statistics
  int unsigned fail_count;
  int unsigned n_writes;
  int unsigned n_decisions;
  int unsigned n_checked;
  int unsigned n_found;
  int unsigned n_boosts;
  int unsigned n_settings;
  int unsigned cycle_count;

  // idling controls shared by the sender, the receiver and the tests
  bit src_gaps;
  bit sink_stalls;
  bit hold_request;

  // running timer tick for the random traffic
  tick_t tick_now;

  // ---------------------------------------------------------------------------
  // failure reporting: the first few are printed, the rest only counted
  // ---------------------------------------------------------------------------
  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: MISMATCH %s", $time, msg);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      note_failure($sformatf("decision %0d field %s: expected %h, got %h",
                             n_checked, name, want, got));
  endfunction

  // ---------------------------------------------------------------------------
  // table predictor
  // ---------------------------------------------------------------------------
  // a level change reloads the slice with slice_unit * (level + 1)
  function automatic slice_t reload_slice(int unsigned lvl);
    return slice_t'(32'(cfg_quantum) * 32'(lvl + 1));
  endfunction

  // apply one accepted beat to the shadow table; decisions queue a pick
  function automatic void track_request(req_beat_t b);
    pick_t       p;
    int unsigned lc;
    int unsigned bottom;
    int unsigned lvl;
    int          best;
    tick_t       tick_gap;

    if (b.func == FUNC_WRITE) begin
      tab_status[b.slot]   = b.status;
      tab_level[b.slot]    = b.level;
      tab_prio[b.slot]     = b.prio;
      tab_created[b.slot]  = b.created;
      tab_slice[b.slot]    = b.slice;
      tab_yields[b.slot]   = b.yields;
      tab_preempts[b.slot] = b.preempts;
      n_writes++;
      return;
    end

    n_decisions++;

    // level count is clamped to 1..MAX_LEVELS
    lc = cfg_levels;
    if (lc < 1) lc = 1;
    if (lc > MAX_LEVELS_DEF) lc = MAX_LEVELS_DEF;
    bottom = lc - 1;

    // demotion of exhausted running entries, then promotion of yielders
    for (int i = 0; i < NSLOT; i++) begin
      if (tab_status[i] == STAT_EMPTY) continue;
      lvl = tab_level[i];
      if (tab_status[i] == STAT_RUNNING && (tab_slice[i] == 0 || tab_slice[i][SLICE_W-1]) &&
          lvl < bottom) begin
        lvl++;
        tab_slice[i] = reload_slice(lvl);
      end
      if (tab_yields[i] > tab_preempts[i] && lvl > 0) begin
        lvl--;
        tab_slice[i] = reload_slice(lvl);
      end
      tab_level[i] = level_t'(lvl);
    end

    // periodic boost, tick distance taken modulo 2^32
    p.boosted = 1'b0;
    tick_gap = b.now - last_boost;
    if (cfg_boost_on && tick_gap >= cfg_interval) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (tab_status[i] != STAT_EMPTY && tab_level[i] > 0) begin
          tab_level[i] = '0;
          tab_slice[i] = slice_t'(32'(cfg_quantum));
        end
      end
      last_boost = b.now;
      p.boosted = 1'b1;
    end

    // least (level, priority, created) among new/ready/running, lowest slot on full tie
    best = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (tab_status[i] < STAT_NEW || tab_status[i] > STAT_RUNNING) continue;
      if (best < 0)
        best = i;
      else if (tab_level[i] < tab_level[best])
        best = i;
      else if (tab_level[i] == tab_level[best]) begin
        if (tab_prio[i] < tab_prio[best])
          best = i;
        else if (tab_prio[i] == tab_prio[best] && tab_created[i] < tab_created[best])
          best = i;
      end
    end

    if (best >= 0) begin
      p.found = 1'b1;
      p.slot  = slot_t'(best);
      p.level = tab_level[best];
      p.slice = tab_slice[best];
      n_found++;
    end else begin
      p.found = 1'b0;
      p.slot  = '0;
      p.level = '0;
      p.slice = '0;
    end
    if (p.boosted) n_boosts++;
    expected_picks.push_back(p);
  endfunction

  // ---------------------------------------------------------------------------
  // observer: samples both channels at the clock edge, before any update lands
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : observe
    req_beat_t seen;
    pick_t     want;
    if (!rst) begin
      if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
        seen.func     = req_ch.func;
        seen.slot     = req_ch.slot;
        seen.status   = req_ch.proc_status;
        seen.level    = req_ch.level_in;
        seen.prio     = req_ch.priority_in;
        seen.created  = req_ch.created_in;
        seen.slice    = req_ch.slice_left_in;
        seen.yields   = req_ch.yields_in;
        seen.preempts = req_ch.preempts_in;
        seen.now      = req_ch.now_tick;
        track_request(seen);
      end
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        if (expected_picks.size() == 0) begin
          note_failure("response beat with no decision pending");
        end else begin
          want = expected_picks.pop_front();
          check_field("found", 32'(want.found), 32'(rsp_ch.found));
          check_field("chosen_slot", 32'(want.slot), 32'(rsp_ch.chosen_slot));
          check_field("chosen_level", 32'(want.level), 32'(rsp_ch.chosen_level));
          check_field("chosen_slice", want.slice, rsp_ch.chosen_slice);
          check_field("boosted", 32'(want.boosted), 32'(rsp_ch.boosted));
          n_checked++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random short stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : drain_side
    int unsigned hold_left;
    rsp_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        hold_left = LONG_HOLD;
        while (hold_left != 0) begin
          @(posedge clk);
          hold_left--;
        end
        rsp_ch.ready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on total run length
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d decisions still due", cycle_count,
             expected_picks.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // beat generation
  // ---------------------------------------------------------------------------
  // write beat with random content, biased toward ties and slice corner values
  function automatic req_beat_t rand_write();
    req_beat_t b;
    b.func   = FUNC_WRITE;
    b.slot   = slot_t'($urandom_range(0, NSLOT - 1));
    b.status = ($urandom_range(0, 3) == 0) ? status_t'($urandom_range(0, 7))
                                           : status_t'($urandom_range(STAT_NEW, STAT_RUNNING));
    b.level  = level_t'($urandom_range(0, 7));
    b.prio   = $urandom_range(0, 1) ? prio_t'($urandom_range(0, 3))
                                    : prio_t'($urandom_range(0, 255));
    b.created = $urandom_range(0, 1) ? tick_t'($urandom_range(0, 7)) : tick_t'($urandom);
    case ($urandom_range(0, 3))
      0: b.slice = '0;
      1: b.slice = slice_t'({1'b1, 31'($urandom)});
      2: b.slice = slice_t'($urandom_range(1, 40));
      default: b.slice = slice_t'($urandom);
    endcase
    b.yields   = $urandom_range(0, 1) ? count_t'($urandom_range(0, 3))
                                      : count_t'($urandom_range(0, 65535));
    b.preempts = $urandom_range(0, 1) ? count_t'($urandom_range(0, 3))
                                      : count_t'($urandom_range(0, 65535));
    b.now = tick_t'($urandom);
    return b;
  endfunction

  // mostly small steps forward, sometimes a jump anywhere or a step back
  function automatic tick_t next_tick();
    case ($urandom_range(0, 15))
      0: tick_now = tick_t'($urandom);
      1: tick_now = tick_now - tick_t'($urandom_range(1, 100));
      default: tick_now = tick_now + tick_t'($urandom_range(0, 150));
    endcase
    return tick_now;
  endfunction

  function automatic req_beat_t make_write(slot_t slot, status_t status, level_t level,
                                           prio_t prio, tick_t created, slice_t slice,
                                           count_t yields, count_t preempts);
    req_beat_t b;
    b = rand_write();
    b.slot     = slot;
    b.status   = status;
    b.level    = level;
    b.prio     = prio;
    b.created  = created;
    b.slice    = slice;
    b.yields   = yields;
    b.preempts = preempts;
    return b;
  endfunction

  // decision beat; the slot fields carry noise the block must ignore
  function automatic req_beat_t make_decision(tick_t now);
    req_beat_t b;
    b = rand_write();
    b.func = FUNC_SCHED;
    b.now  = now;
    return b;
  endfunction

  function automatic req_beat_t rand_beat();
    if ($urandom_range(0, 99) < SCHED_PCT) return make_decision(next_tick());
    return rand_write();
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  task automatic drive_fields(input req_beat_t b);
    req_ch.func          <= b.func;
    req_ch.slot          <= b.slot;
    req_ch.proc_status   <= b.status;
    req_ch.level_in      <= b.level;
    req_ch.priority_in   <= b.prio;
    req_ch.created_in    <= b.created;
    req_ch.slice_left_in <= b.slice;
    req_ch.yields_in     <= b.yields;
    req_ch.preempts_in   <= b.preempts;
    req_ch.now_tick      <= b.now;
  endtask

  // offer one beat, maybe after a short idle burst, and return once it is taken;
  // valid stays high so the next call can follow in the same cycle
  task automatic send_beat(input req_beat_t b);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    drive_fields(b);
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  // stop offering and wait for every pending decision to come back
  task automatic wait_picks_drained();
    int unsigned guard;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (expected_picks.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------
  function automatic logic [PDATA_W-1:0] reg_shadow(logic [1:0] idx);
    case (idx)
      REG_BOOST_ON:       return PDATA_W'(cfg_boost_on);
      REG_BOOST_INTERVAL: return PDATA_W'(cfg_interval);
      REG_LEVEL_COUNT:    return PDATA_W'(cfg_levels);
      default:            return PDATA_W'(cfg_quantum);
    endcase
  endfunction

  task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_BOOST_ON:       cfg_boost_on = val[0];
      REG_BOOST_INTERVAL: cfg_interval = val[TICK_W-1:0];
      REG_LEVEL_COUNT:    cfg_levels   = val[LCOUNT_W-1:0];
      default:            cfg_quantum  = val[QUANTUM_W-1:0];
    endcase
    @(posedge clk);
  endtask

  task automatic apb_readback(input logic [1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== reg_shadow(idx))
      note_failure($sformatf("register %0d readback: expected %h, got %h",
                             idx, reg_shadow(idx), prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // registers change only with the block idle: no decision due and the walk finished
  task automatic program_regs(input logic boost_en, input logic [TICK_W-1:0] interval,
                              input logic [LCOUNT_W-1:0] levels,
                              input logic [QUANTUM_W-1:0] quantum);
    wait_picks_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(REG_BOOST_ON, PDATA_W'(boost_en));
    apb_write(REG_BOOST_INTERVAL, PDATA_W'(interval));
    apb_write(REG_LEVEL_COUNT, PDATA_W'(levels));
    apb_write(REG_SLICE_UNIT, PDATA_W'(quantum));
    apb_readback(REG_BOOST_ON);
    apb_readback(REG_BOOST_INTERVAL);
    apb_readback(REG_LEVEL_COUNT);
    apb_readback(REG_SLICE_UNIT);
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // default registers: empty table, field extremes, demotion, promotion, ties
  task automatic test_directed_table();
    // nothing schedulable yet: all-zero pick
    send_beat(make_decision(32'd0));
    // slot 31 with level, priority, created, slice and preemptions at their top values
    send_beat(make_write(5'd31, STAT_NEW, 3'd7, 8'hFF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF,
                         16'd0, 16'hFFFF));
    send_beat(make_decision(32'd1));
    // running with no slice left: demoted one level with a fresh slice
    send_beat(make_write(5'd0, STAT_RUNNING, 3'd0, 8'd0, 32'd0, 32'sd0, 16'd0, 16'd0));
    // same key as slot 0 after its demotion: lowest slot must win the tie
    send_beat(make_write(5'd5, STAT_READY, 3'd1, 8'd0, 32'd0, -32'sd5, 16'd0, 16'd0));
    send_beat(make_decision(32'd2));
    // negative slice at the bottom level, and a level written below the bottom
    send_beat(make_write(5'd6, STAT_RUNNING, 3'd2, 8'd0, 32'd0, 32'sh8000_0000, 16'd0,
                         16'd0));
    send_beat(make_write(5'd7, STAT_RUNNING, 3'd6, 8'd0, 32'd0, -32'sd1, 16'd0, 16'd0));
    // more yields than preemptions: promoted, but not past level zero
    send_beat(make_write(5'd8, STAT_READY, 3'd3, 8'd0, 32'd0, 32'sd99, 16'hFFFF, 16'hFFFE));
    send_beat(make_write(5'd9, STAT_NEW, 3'd0, 8'h80, 32'd5, 32'sd1234, 16'd5, 16'd1));
    // blocked and other codes hold the best key but are never picked
    send_beat(make_write(5'd10, STAT_BLOCKED, 3'd0, 8'd0, 32'd0, 32'sd0, 16'd0, 16'd0));
    send_beat(make_write(5'd11, STAT_OTHER_LO, 3'd0, 8'd0, 32'd0, 32'sd0, 16'd0, 16'd0));
    send_beat(make_write(5'd12, STAT_OTHER_HI, 3'd0, 8'd0, 32'd0, 32'sd0, 16'd9, 16'd0));
    send_beat(make_decision(32'd3));
    // emptying a slot takes it out of the race
    send_beat(make_write(5'd9, STAT_EMPTY, 3'd0, 8'd0, 32'd0, 32'sd0, 16'd0, 16'd0));
    send_beat(make_decision(32'd4));
    // slot 0 exhausted again: demoted, the promoted slot 8 now leads
    send_beat(make_write(5'd0, STAT_RUNNING, 3'd1, 8'd0, 32'd0, 32'sd0, 16'd0, 16'd0));
    send_beat(make_decision(32'd5));
  endtask

  // register extremes: zero interval, zero quantum, clamped level counts, wrap of ticks
  task automatic test_register_corners();
    // boost every decision, level count zero acts as one, reloads give zero slices
    program_regs(1'b1, 32'd0, 4'd0, 16'd0);
    send_beat(make_decision(32'd7));
    send_beat(make_write(5'd2, STAT_RUNNING, 3'd0, 8'd0, 32'd0, 32'sd0, 16'd0, 16'd0));
    send_beat(make_decision(32'd8));
    // widest interval: two ticks back is just short of it, one tick back reaches it
    program_regs(1'b1, 32'hFFFF_FFFF, 4'd15, 16'hFFFF);
    send_beat(make_write(5'd3, STAT_RUNNING, 3'd6, 8'd1, 32'd0, 32'sd0, 16'd0, 16'd0));
    send_beat(make_decision(32'd6));
    send_beat(make_decision(32'd7));
    tick_now = 32'd7;
  endtask

  // random traffic under the current registers; optional full drain half way
  task automatic test_random_mix(input int unsigned n_items, input bit pause_midway);
    for (int unsigned k = 0; k < n_items; k++) begin
      if (pause_midway && k == n_items / 2) wait_picks_drained();
      send_beat(rand_beat());
    end
  endtask

  // receiver holds off for a long stretch while decisions keep coming
  task automatic test_backpressure();
    program_regs(1'($urandom_range(0, 1)), tick_t'($urandom), 4'd1, 16'd1);
    repeat (8) send_beat(rand_write());
    hold_request = 1'b1;
    repeat (8) send_beat(make_decision(next_tick()));
    test_random_mix(64, 1'b0);
  endtask

  // back-to-back traffic, no idling on either side
  task automatic test_quiet_stream();
    program_regs(1'b1, BOOST_INTERVAL_RST, LEVEL_COUNT_RST, SLICE_UNIT_RST);
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    test_random_mix(120, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    // every input known from time zero
    rst     <= 1'b1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    req_ch.valid <= 1'b0;
    drive_fields(rand_write());

    for (int i = 0; i < NSLOT; i++) begin
      tab_status[i]   = STAT_EMPTY;
      tab_level[i]    = '0;
      tab_prio[i]     = '0;
      tab_created[i]  = '0;
      tab_slice[i]    = '0;
      tab_yields[i]   = '0;
      tab_preempts[i] = '0;
    end
    last_boost   = '0;
    cfg_boost_on = BOOST_ON_RST;
    cfg_interval = BOOST_INTERVAL_RST;
    cfg_levels   = LEVEL_COUNT_RST;
    cfg_quantum  = SLICE_UNIT_RST;
    tick_now     = '0;
    src_gaps     = 1'b1;
    sink_stalls  = 1'b1;
    hold_request = 1'b0;

    // hold synchronous reset, then release it before the directed tests
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_table();
    test_register_corners();

    program_regs(1'b1, 32'd0, 4'd0, 16'd0);
    test_random_mix(80, 1'b0);
    program_regs(1'b1, 32'hFFFF_FFFF, 4'd15, 16'hFFFF);
    test_random_mix(80, 1'b0);
    program_regs(1'b1, tick_t'($urandom_range(20, 400)), 4'd8,
                 16'($urandom_range(1, 65535)));
    test_random_mix(120, 1'b1);
    test_backpressure();
    program_regs(1'($urandom_range(0, 1)),
                 $urandom_range(0, 1) ? tick_t'($urandom_range(0, 300)) : tick_t'($urandom),
                 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
    test_random_mix(120, 1'b0);
    test_quiet_stream();

    // let the last decisions come back, settle, then check that none is left
    wait_picks_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_picks.size() != 0)
      note_failure($sformatf("%0d decisions never answered", expected_picks.size()));

    $display("covered %0d slot writes and %0d decisions (%0d picks, %0d boosts) over %0d settings",
             n_writes, n_decisions, n_found, n_boosts, n_settings);
    $display("checked %0d response beats in %0d cycles, incl. a %0d-cycle receiver hold-off",
             n_checked, cycle_count, LONG_HOLD);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mlfq_pkg.sv
rtl/core/mlfq_req_if.sv
rtl/core/mlfq_rsp_if.sv
rtl/core/mlfq_ram.sv
rtl/core/mlfq_process_selector.sv
tb/testbench.sv
